[hdl/subregion_copy_burst_generator_top_assert.svh]
// Assertion macros used by the burst generator controller.
// Expects clk and rst_n in the scope where a macro is expanded.
`ifndef SUBREGION_COPY_BURST_GENERATOR_TOP_ASSERT_SVH
`define SUBREGION_COPY_BURST_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SCBG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scbg same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SCBG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scbg next-cycle check failed");

`endif

[hdl/scbg_pkg.sv]
// Shared types and constants for the sub-box burst generator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package scbg_pkg;

    // Fixed field widths of the ports
    localparam int FIELD_W    = 32;
    localparam int OUT_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Configuration register widths
    localparam int DIMS_W  = 2;
    localparam int ELEM_W  = 16;
    localparam int LEN_W   = 32;
    localparam int BASE_W  = 48;

    // Shared multiplier and product register shape
    localparam int MA_W    = 33;
    localparam int MB_W    = 32;
    localparam int PROD_W  = 64;
    localparam int HALF    = 32;

    localparam int NUM_DIMS = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIMS         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PACKED_BASE  = 3'd5;

    // Dimension counts
    localparam logic [DIMS_W-1:0] DIMS_NONE = 2'd0;
    localparam logic [DIMS_W-1:0] DIMS_1D   = 2'd1;
    localparam logic [DIMS_W-1:0] DIMS_2D   = 2'd2;
    localparam logic [DIMS_W-1:0] DIMS_3D   = 2'd3;

    // Request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_NEXT  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_PLO,
        ST_PHI,
        ST_MID,
        ST_SUM,
        ST_ELO,
        ST_EHI,
        ST_LEN,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROW,
        OP_PLO,
        OP_PHI,
        OP_MID,
        OP_SUM,
        OP_ELO,
        OP_EHI,
        OP_LEN,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic start_ok;
        logic dims3;
        logic last_burst;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[hdl/scbg_ctrl.sv]
// Controller state machine for the burst generator: sequences the datapath.
// Depends on scbg_pkg and the assertion macro header.
`default_nettype none
`include "subregion_copy_burst_generator_top_assert.svh"

module scbg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            kind,
    output scbg_pkg::cmd_t  cmd,
    input  scbg_pkg::stat_t stat
);
    import scbg_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        busy_reg, busy_next;
    logic        accept;
    logic        plane_step;
    logic        next_dropped;
    logic        emit_stall;

    assign accept = in_valid && in_ready;

    // Next state and busy flag
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_START)
                    begin
                        busy_next  = stat.start_ok;
                        state_next = stat.start_ok ? ST_ROW : ST_IDLE;
                    end
                    else if (busy_reg)
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:  state_next = stat.dims3 ? ST_PLO : ST_SUM;
            ST_PLO:  state_next = ST_PHI;
            ST_PHI:  state_next = ST_MID;
            ST_MID:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ELO;
            ST_ELO:  state_next = ST_EHI;
            ST_EHI:  state_next = ST_LEN;
            ST_LEN:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                    if (stat.last_burst)
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Drive the datapath command and input ready
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && kind == KIND_START)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_ROW:  cmd.op = OP_ROW;
            ST_PLO:  cmd.op = OP_PLO;
            ST_PHI:  cmd.op = OP_PHI;
            ST_MID:  cmd.op = OP_MID;
            ST_SUM:  cmd.op = OP_SUM;
            ST_ELO:  cmd.op = OP_ELO;
            ST_EHI:  cmd.op = OP_EHI;
            ST_LEN:  cmd.op = OP_LEN;
            ST_EMIT: cmd.op = stat.out_free ? OP_EMIT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    // Conditions watched by the checks below
    assign plane_step   = (state_reg == ST_PLO) || (state_reg == ST_PHI) || (state_reg == ST_MID);
    assign next_dropped = accept && (kind == KIND_NEXT) && !busy_reg;
    assign emit_stall   = (state_reg == ST_EMIT) && !stat.out_free;

    `SCBG_ASSERT_SAME(a_busy_while_working, state_reg != ST_IDLE, busy_reg)
    `SCBG_ASSERT_SAME(a_plane_steps_only_3d, plane_step, stat.dims3)
    `SCBG_ASSERT_NEXT(a_idle_next_dropped, next_dropped, state_reg == ST_IDLE)
    `SCBG_ASSERT_NEXT(a_emit_holds_on_stall, emit_stall, state_reg == ST_EMIT)

endmodule

`default_nettype wire

[hdl/scbg_datapath.sv]
// Datapath of the burst generator: config registers, box latches, shared
// multiplier, accumulator, cursor and output register. Depends on scbg_pkg.
`default_nettype none

module scbg_datapath #(
    parameter int ADDR_BITS = 48,
    parameter int DIM_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  scbg_pkg::cmd_t                   cmd,
    output scbg_pkg::stat_t                  stat,
    input  logic                             cfg_valid,
    input  logic [scbg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scbg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             to_packed,
    input  logic [scbg_pkg::FIELD_W-1:0]     start_d0,
    input  logic [scbg_pkg::FIELD_W-1:0]     start_d1,
    input  logic [scbg_pkg::FIELD_W-1:0]     start_d2,
    input  logic [scbg_pkg::FIELD_W-1:0]     extent_d0,
    input  logic [scbg_pkg::FIELD_W-1:0]     extent_d1,
    input  logic [scbg_pkg::FIELD_W-1:0]     extent_d2,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [scbg_pkg::OUT_W-1:0]       region_addr,
    output logic [scbg_pkg::OUT_W-1:0]       packed_addr,
    output logic [scbg_pkg::OUT_W-1:0]       burst_bytes,
    output logic                             direction,
    output logic                             final_burst
);
    import scbg_pkg::*;

    // Configuration registers
    logic [DIMS_W-1:0] dims_reg,  dims_next;
    logic [ELEM_W-1:0] elem_reg,  elem_next;
    logic [LEN_W-1:0]  row_reg,   row_next;
    logic [LEN_W-1:0]  plane_reg, plane_next;
    logic [BASE_W-1:0] rbase_reg, rbase_next;
    logic [BASE_W-1:0] pbase_reg, pbase_next;

    // Box state
    logic [DIMS_W-1:0]    dims_latch_reg, dims_latch_next;
    logic                 dir_reg, dir_next;
    logic [DIM_BITS-1:0]  off_reg [NUM_DIMS];
    logic [DIM_BITS-1:0]  off_next [NUM_DIMS];
    logic [DIM_BITS-1:0]  ext_reg [NUM_DIMS];
    logic [DIM_BITS-1:0]  ext_next [NUM_DIMS];
    logic [DIM_BITS-1:0]  oc_reg, oc_next;
    logic [DIM_BITS-1:0]  mc_reg, mc_next;
    logic [ADDR_BITS-1:0] cursor_reg, cursor_next;

    // Arithmetic registers
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [ADDR_BITS-1:0] acc_reg, acc_next;
    logic [ADDR_BITS-1:0] t_reg, t_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] region_addr_reg, region_addr_next;
    logic [OUT_W-1:0] packed_addr_reg, packed_addr_next;
    logic [OUT_W-1:0] burst_bytes_reg, burst_bytes_next;
    logic             direction_reg, direction_next;
    logic             final_burst_reg, final_burst_next;

    // Combinational helpers
    logic [MA_W-1:0]         mul_a;
    logic [MB_W-1:0]         mul_b;
    logic [MA_W+MB_W-1:0]    mul_full;
    logic [PROD_W-1:0]       mul_res;
    logic [DIM_BITS:0]       row_sum;
    logic [DIM_BITS:0]       mid_sum;
    logic [PROD_W-1:0]       t_wide;
    logic [PROD_W-1:0]       shl_wide;
    logic [ADDR_BITS-1:0]    hi_shift;
    logic [ADDR_BITS-1:0]    prod_a;
    logic [ADDR_BITS-1:0]    inner_off;
    logic [DIM_BITS-1:0]     inner_ext;
    logic [ADDR_BITS-1:0]    rbase_a;
    logic [ADDR_BITS-1:0]    pbase_a;
    logic [ADDR_BITS-1:0]    region_sum;
    logic [ADDR_BITS-1:0]    packed_sum;
    logic [DIM_BITS:0]       oc_inc;
    logic [DIM_BITS:0]       mc_inc;
    logic                    mc_wrap;
    logic                    last;
    logic                    e0_zero;
    logic                    e1_zero;
    logic                    start_ok;

    // Configuration writes
    always_comb
    begin
        dims_next  = dims_reg;
        elem_next  = elem_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        rbase_next = rbase_reg;
        pbase_next = pbase_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DIMS:         dims_next  = cfg_data[DIMS_W-1:0];
                REG_ELEM_BYTES:   elem_next  = cfg_data[ELEM_W-1:0];
                REG_ROW_LENGTH:   row_next   = cfg_data[LEN_W-1:0];
                REG_PLANE_LENGTH: plane_next = cfg_data[LEN_W-1:0];
                REG_REGION_BASE:  rbase_next = cfg_data[BASE_W-1:0];
                REG_PACKED_BASE:  pbase_next = cfg_data[BASE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Start check on the live dims register and the incoming extents
    assign e0_zero = (extent_d0[DIM_BITS-1:0] == '0);
    assign e1_zero = (extent_d1[DIM_BITS-1:0] == '0);

    always_comb
    begin
        case (dims_reg)
            DIMS_1D: start_ok = 1'b1;
            DIMS_2D: start_ok = !e0_zero;
            DIMS_3D: start_ok = !e0_zero && !e1_zero;
            default: start_ok = 1'b0;
        endcase
    end

    // Operand sources
    assign row_sum  = {1'b0, off_reg[0]} + {1'b0, oc_reg};
    assign mid_sum  = {1'b0, off_reg[1]} + {1'b0, mc_reg};
    assign t_wide   = PROD_W'(t_reg);
    assign shl_wide = {prod_reg[HALF-1:0], {HALF{1'b0}}};
    assign hi_shift = shl_wide[ADDR_BITS-1:0];
    assign prod_a   = prod_reg[ADDR_BITS-1:0];
    assign rbase_a  = ADDR_BITS'(rbase_reg);
    assign pbase_a  = ADDR_BITS'(pbase_reg);

    // Select the innermost offset and extent by dimension count
    always_comb
    begin
        case (dims_latch_reg)
            DIMS_2D:
            begin
                inner_off = ADDR_BITS'(off_reg[1]);
                inner_ext = ext_reg[1];
            end
            DIMS_3D:
            begin
                inner_off = ADDR_BITS'(off_reg[2]);
                inner_ext = ext_reg[2];
            end
            default:
            begin
                inner_off = '0;
                inner_ext = ext_reg[0];
            end
        endcase
    end

    // Multiplier operand select
    always_comb
    begin
        case (cmd.op)
            OP_ROW:
            begin
                mul_a = MA_W'(row_sum);
                mul_b = (dims_latch_reg == DIMS_1D) ? MB_W'(1) : row_reg;
            end
            OP_PLO:
            begin
                mul_a = MA_W'(prod_reg[HALF-1:0]);
                mul_b = plane_reg;
            end
            OP_PHI:
            begin
                mul_a = MA_W'(t_wide[PROD_W-1:HALF]);
                mul_b = plane_reg;
            end
            OP_MID:
            begin
                mul_a = MA_W'(mid_sum);
                mul_b = plane_reg;
            end
            OP_ELO:
            begin
                mul_a = MA_W'(t_wide[HALF-1:0]);
                mul_b = MB_W'(elem_reg);
            end
            OP_EHI:
            begin
                mul_a = MA_W'(t_wide[PROD_W-1:HALF]);
                mul_b = MB_W'(elem_reg);
            end
            OP_LEN:
            begin
                mul_a = MA_W'(inner_ext);
                mul_b = MB_W'(elem_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_res  = mul_full[PROD_W-1:0];

    // Burst position advance and last-burst decision
    assign oc_inc  = {1'b0, oc_reg} + (DIM_BITS+1)'(1);
    assign mc_inc  = {1'b0, mc_reg} + (DIM_BITS+1)'(1);
    assign mc_wrap = (mc_inc >= {1'b0, ext_reg[1]});

    always_comb
    begin
        case (dims_latch_reg)
            DIMS_2D: last = (oc_inc >= {1'b0, ext_reg[0]});
            DIMS_3D: last = ((mc_wrap ? oc_inc : {1'b0, oc_reg}) >= {1'b0, ext_reg[0]});
            default: last = 1'b1;
        endcase
    end

    assign region_sum = rbase_a + acc_reg;
    assign packed_sum = pbase_a + cursor_reg;

    // Step the datapath by command
    always_comb
    begin
        dims_latch_next  = dims_latch_reg;
        dir_next         = dir_reg;
        off_next         = off_reg;
        ext_next         = ext_reg;
        oc_next          = oc_reg;
        mc_next          = mc_reg;
        cursor_next      = cursor_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        t_next           = t_reg;
        region_addr_next = region_addr_reg;
        packed_addr_next = packed_addr_reg;
        burst_bytes_next = burst_bytes_reg;
        direction_next   = direction_reg;
        final_burst_next = final_burst_reg;
        out_valid_next   = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                dir_next        = to_packed;
                off_next[0]     = start_d0[DIM_BITS-1:0];
                off_next[1]     = start_d1[DIM_BITS-1:0];
                off_next[2]     = start_d2[DIM_BITS-1:0];
                ext_next[0]     = extent_d0[DIM_BITS-1:0];
                ext_next[1]     = extent_d1[DIM_BITS-1:0];
                ext_next[2]     = extent_d2[DIM_BITS-1:0];
                dims_latch_next = dims_reg;
                oc_next         = '0;
                mc_next         = '0;
                cursor_next     = '0;
            end
            OP_ROW:
            begin
                prod_next = mul_res;
                acc_next  = '0;
            end
            OP_PLO:
            begin
                t_next    = prod_a;
                prod_next = mul_res;
            end
            OP_PHI:
            begin
                acc_next  = prod_a;
                prod_next = mul_res;
            end
            OP_MID:
            begin
                acc_next  = acc_reg + hi_shift;
                prod_next = mul_res;
            end
            OP_SUM:
            begin
                t_next = acc_reg + prod_a + inner_off;
            end
            OP_ELO:
            begin
                prod_next = mul_res;
            end
            OP_EHI:
            begin
                acc_next  = prod_a;
                prod_next = mul_res;
            end
            OP_LEN:
            begin
                acc_next  = acc_reg + hi_shift;
                prod_next = mul_res;
            end
            OP_EMIT:
            begin
                region_addr_next = OUT_W'(region_sum);
                packed_addr_next = OUT_W'(packed_sum);
                burst_bytes_next = OUT_W'(prod_a);
                direction_next   = dir_reg;
                final_burst_next = last;
                out_valid_next   = 1'b1;
                cursor_next      = cursor_reg + prod_a;
                case (dims_latch_reg)
                    DIMS_2D:
                    begin
                        oc_next = oc_inc[DIM_BITS-1:0];
                    end
                    DIMS_3D:
                    begin
                        if (mc_wrap)
                        begin
                            mc_next = '0;
                            oc_next = oc_inc[DIM_BITS-1:0];
                        end
                        else
                        begin
                            mc_next = mc_inc[DIM_BITS-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg       <= DIMS_1D;
            elem_reg       <= ELEM_W'(1);
            row_reg        <= LEN_W'(1);
            plane_reg      <= LEN_W'(1);
            rbase_reg      <= '0;
            pbase_reg      <= '0;
            dims_latch_reg <= DIMS_NONE;
            dir_reg        <= 1'b0;
            oc_reg         <= '0;
            mc_reg         <= '0;
            cursor_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            dims_reg       <= dims_next;
            elem_reg       <= elem_next;
            row_reg        <= row_next;
            plane_reg      <= plane_next;
            rbase_reg      <= rbase_next;
            pbase_reg      <= pbase_next;
            dims_latch_reg <= dims_latch_next;
            dir_reg        <= dir_next;
            oc_reg         <= oc_next;
            mc_reg         <= mc_next;
            cursor_reg     <= cursor_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        off_reg         <= off_next;
        ext_reg         <= ext_next;
        prod_reg        <= prod_next;
        acc_reg         <= acc_next;
        t_reg           <= t_next;
        region_addr_reg <= region_addr_next;
        packed_addr_reg <= packed_addr_next;
        burst_bytes_reg <= burst_bytes_next;
        direction_reg   <= direction_next;
        final_burst_reg <= final_burst_next;
    end

    assign out_valid   = out_valid_reg;
    assign region_addr = region_addr_reg;
    assign packed_addr = packed_addr_reg;
    assign burst_bytes = burst_bytes_reg;
    assign direction   = direction_reg;
    assign final_burst = final_burst_reg;

    assign stat.start_ok   = start_ok;
    assign stat.dims3      = (dims_latch_reg == DIMS_3D);
    assign stat.last_burst = last;
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

[hdl/subregion_copy_burst_generator_top.sv]
// Sub-box burst address generator top level: joins scbg_ctrl and scbg_datapath.
// A burst passes states ROW, SUM, ELO, EHI, LEN, EMIT (3D adds PLO, PHI, MID
// after ROW) into the output register, paced by the single shared 33x32
// multiplier; EMIT holds while the output stalls. A new item is taken only in
// idle; one giving no burst leaves it idle. Reset is asynchronous, active low:
// idle, no box, registers at dims 1, elem_bytes 1, row/plane length 1, bases 0.
`default_nettype none

module subregion_copy_burst_generator_top #(
    parameter int ADDR_BITS = 48,
    parameter int DIM_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scbg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scbg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic                             to_packed,
    input  logic [scbg_pkg::FIELD_W-1:0]     start_d0,
    input  logic [scbg_pkg::FIELD_W-1:0]     start_d1,
    input  logic [scbg_pkg::FIELD_W-1:0]     start_d2,
    input  logic [scbg_pkg::FIELD_W-1:0]     extent_d0,
    input  logic [scbg_pkg::FIELD_W-1:0]     extent_d1,
    input  logic [scbg_pkg::FIELD_W-1:0]     extent_d2,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [scbg_pkg::OUT_W-1:0]       region_addr,
    output logic [scbg_pkg::OUT_W-1:0]       packed_addr,
    output logic [scbg_pkg::OUT_W-1:0]       burst_bytes,
    output logic                             direction,
    output logic                             final_burst
);
    import scbg_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Configuration writes are always accepted and registered directly
    assign cfg_ready = 1'b1;

    scbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .cmd      (cmd),
        .stat     (stat)
    );

    scbg_datapath #(
        .ADDR_BITS (ADDR_BITS),
        .DIM_BITS  (DIM_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .to_packed   (to_packed),
        .start_d0    (start_d0),
        .start_d1    (start_d1),
        .start_d2    (start_d2),
        .extent_d0   (extent_d0),
        .extent_d1   (extent_d1),
        .extent_d2   (extent_d2),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .region_addr (region_addr),
        .packed_addr (packed_addr),
        .burst_bytes (burst_bytes),
        .direction   (direction),
        .final_burst (final_burst)
    );

endmodule

`default_nettype wire
